>>> sv/bldq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldq_pkg
// Shared types and codes for the bounded list deque engine.
// ----------------------------------------------------------------------------
package bldq_pkg;

  // stream payload widths (fields packed from bit 0 up, padded to bytes)
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - STATUS_W - VALUE_W - INDEX_W - COUNT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_DELETE     = 3'd5,
    MODE_REVERSE    = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_t;

  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_MOVE_RD   = 11'b000_0000_0010,
    S_MOVE_WR   = 11'b000_0000_0100,
    S_PUT       = 11'b000_0000_1000,
    S_SWAP_RDLO = 11'b000_0001_0000,
    S_SWAP_RDHI = 11'b000_0010_0000,
    S_SWAP_WRLO = 11'b000_0100_0000,
    S_SWAP_WRHI = 11'b000_1000_0000,
    S_DUMP_RD   = 11'b001_0000_0000,
    S_DUMP_LD   = 11'b010_0000_0000,
    S_DUMP_WAIT = 11'b100_0000_0000
  } state_t;

endpackage

>>> sv/bldq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bldq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bldq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/bounded_list_deque_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_deque_engine_unit
// Bounded list with push/pop at both ends, positional insert/delete, reverse
// and clear; dumps the whole list front to back after every request.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser     | tlast
//  in_     | in  | mode[2:0] value[34:3] position[39:35]     | -         | -
//  out_    | out | status[1:0] item_value[33:2]              | empty_res | last
//          |     | item_index[37:34] count[42:38] zero pad   |           |
//
//  One request at a time; in_tready is high only while idle.
//  Update: push/insert move each word behind the slot back (RAM read, then
//  write), then write the value; pop/delete move words forward; reverse swaps
//  pairs (read low, read high, write low, write high). Dump: registered RAM
//  read, then output beat, per word, with out_tready stalls. All share one RAM port.
//  rst_n (synchronous) empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_list_deque_engine_unit #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bldq_pkg::IN_TDATA_W-1:0]    in_tdata,  // mode, value, position
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bldq_pkg::OUT_TDATA_W-1:0]   out_tdata, // status, item_value,
                                                        // item_index, count, pad
  output logic                               out_tuser, // empty_res
  output logic                               out_tlast
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > bldq_pkg::POS_W) ? CW : bldq_pkg::POS_W;

  // input fields
  bldq_pkg::mode_t                  in_mode;
  logic [bldq_pkg::VALUE_W-1:0]     in_value;
  logic [bldq_pkg::POS_W-1:0]       in_position;

  assign in_mode     = bldq_pkg::mode_t'(in_tdata[2:0]);
  assign in_value    = in_tdata[34:3];
  assign in_position = in_tdata[39:35];

  // registers
  bldq_pkg::state_t                 state_r, state_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [CW-1:0]                    ptr_r, ptr_nxt;
  logic [CW-1:0]                    end_r, end_nxt;
  logic                             ins_r, ins_nxt;
  logic [DATA_WIDTH-1:0]            val_r, val_nxt;
  logic [bldq_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [bldq_pkg::VALUE_W-1:0]     oval_r, oval_nxt;

  // RAM port
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [DATA_WIDTH-1:0]            ram_wdata;
  logic [AW-1:0]                    ram_raddr;
  logic [DATA_WIDTH-1:0]            ram_rdata;

  bldq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request decode
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] ins_idx;
  logic [CW-1:0] del_idx;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] mv_src;
  logic          full;
  logic          empty;
  logic          dump_last;

  assign pos_x  = XW'(in_position);
  assign cnt_x  = XW'(cnt_r);
  assign cnt_m1 = cnt_r - CW'(1);
  assign full   = (cnt_r == CW'(CAPACITY));
  assign empty  = (cnt_r == '0);

  always_comb begin
    priority if (in_mode == bldq_pkg::MODE_PUSH_FRONT) begin
      ins_idx = '0;
    end else if (in_mode == bldq_pkg::MODE_PUSH_BACK || pos_x > cnt_x) begin
      ins_idx = cnt_r;
    end else begin
      ins_idx = CW'(pos_x);
    end
  end

  // delete position is 1-based: zero acts as one, beyond count as count
  always_comb begin
    priority if (in_mode == bldq_pkg::MODE_POP_FRONT || pos_x == '0
                 && in_mode == bldq_pkg::MODE_DELETE) begin
      del_idx = '0;
    end else if (in_mode == bldq_pkg::MODE_POP_BACK || pos_x > cnt_x) begin
      del_idx = cnt_m1;
    end else begin
      del_idx = CW'(pos_x - XW'(1));
    end
  end

  // insert shifts towards the back (source below), delete towards the front
  assign mv_src    = ins_r ? (ptr_r - CW'(1)) : (ptr_r + CW'(1));
  assign dump_last = empty || (ptr_r == cnt_m1);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    end_nxt    = end_r;
    ins_nxt    = ins_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    oval_nxt   = oval_r;
    ram_we     = 1'b0;
    ram_waddr  = ptr_r[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = ptr_r[AW-1:0];

    unique case (state_r)
      bldq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          val_nxt    = DATA_WIDTH'(in_value);
          status_nxt = bldq_pkg::STS_OK;
          ptr_nxt    = '0;
          state_nxt  = bldq_pkg::S_DUMP_RD;
          unique case (in_mode)
            bldq_pkg::MODE_PUSH_FRONT,
            bldq_pkg::MODE_PUSH_BACK,
            bldq_pkg::MODE_INSERT: begin
              if (full) begin
                status_nxt = bldq_pkg::STS_FULL;
              end else begin
                ins_nxt   = 1'b1;
                end_nxt   = ins_idx;
                ptr_nxt   = cnt_r;
                state_nxt = (cnt_r == ins_idx) ? bldq_pkg::S_PUT : bldq_pkg::S_MOVE_RD;
              end
            end
            bldq_pkg::MODE_POP_FRONT,
            bldq_pkg::MODE_POP_BACK,
            bldq_pkg::MODE_DELETE: begin
              if (empty) begin
                status_nxt = bldq_pkg::STS_EMPTY;
              end else if (del_idx == cnt_m1) begin
                cnt_nxt = cnt_m1;
              end else begin
                ins_nxt   = 1'b0;
                end_nxt   = cnt_m1;
                ptr_nxt   = del_idx;
                state_nxt = bldq_pkg::S_MOVE_RD;
              end
            end
            bldq_pkg::MODE_REVERSE: begin
              if (cnt_r > CW'(1)) begin
                end_nxt   = cnt_m1;
                state_nxt = bldq_pkg::S_SWAP_RDLO;
              end
            end
            bldq_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end

      bldq_pkg::S_MOVE_RD: begin
        ram_raddr = mv_src[AW-1:0];
        state_nxt = bldq_pkg::S_MOVE_WR;
      end

      bldq_pkg::S_MOVE_WR: begin
        ram_we  = 1'b1;
        ptr_nxt = ins_r ? (ptr_r - CW'(1)) : (ptr_r + CW'(1));
        if (ptr_nxt == end_r) begin
          if (ins_r) begin
            state_nxt = bldq_pkg::S_PUT;
          end else begin
            cnt_nxt   = cnt_m1;
            ptr_nxt   = '0;
            state_nxt = bldq_pkg::S_DUMP_RD;
          end
        end else begin
          state_nxt = bldq_pkg::S_MOVE_RD;
        end
      end

      bldq_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        ptr_nxt   = '0;
        state_nxt = bldq_pkg::S_DUMP_RD;
      end

      bldq_pkg::S_SWAP_RDLO: begin
        state_nxt = bldq_pkg::S_SWAP_RDHI;
      end

      // low word lands now; hold it while the high word is read
      bldq_pkg::S_SWAP_RDHI: begin
        ram_raddr = end_r[AW-1:0];
        val_nxt   = ram_rdata;
        state_nxt = bldq_pkg::S_SWAP_WRLO;
      end

      bldq_pkg::S_SWAP_WRLO: begin
        ram_we    = 1'b1;
        state_nxt = bldq_pkg::S_SWAP_WRHI;
      end

      bldq_pkg::S_SWAP_WRHI: begin
        ram_we    = 1'b1;
        ram_waddr = end_r[AW-1:0];
        ram_wdata = val_r;
        if ((ptr_r + CW'(2)) < end_r) begin
          ptr_nxt   = ptr_r + CW'(1);
          end_nxt   = end_r - CW'(1);
          state_nxt = bldq_pkg::S_SWAP_RDLO;
        end else begin
          ptr_nxt   = '0;
          state_nxt = bldq_pkg::S_DUMP_RD;
        end
      end

      bldq_pkg::S_DUMP_RD: begin
        if (empty) begin
          oval_nxt  = '0;
          state_nxt = bldq_pkg::S_DUMP_WAIT;
        end else begin
          state_nxt = bldq_pkg::S_DUMP_LD;
        end
      end

      bldq_pkg::S_DUMP_LD: begin
        oval_nxt  = bldq_pkg::VALUE_W'(ram_rdata);
        state_nxt = bldq_pkg::S_DUMP_WAIT;
      end

      bldq_pkg::S_DUMP_WAIT: begin
        if (out_tready) begin
          if (dump_last) begin
            state_nxt = bldq_pkg::S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + CW'(1);
            ram_raddr = ptr_nxt[AW-1:0];
            state_nxt = bldq_pkg::S_DUMP_LD;
          end
        end
      end

      default: begin
        state_nxt = bldq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bldq_pkg::S_IDLE;
      cnt_r   <= '0;
      ptr_r   <= '0;
      end_r   <= '0;
      ins_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      end_r   <= end_nxt;
      ins_r   <= ins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    status_r <= status_nxt;
    oval_r   <= oval_nxt;
  end

  assign in_tready  = (state_r == bldq_pkg::S_IDLE);
  assign out_tvalid = (state_r == bldq_pkg::S_DUMP_WAIT);
  assign out_tdata  = {{bldq_pkg::OUT_PAD_W{1'b0}},
                       bldq_pkg::COUNT_W'(cnt_r),
                       bldq_pkg::INDEX_W'(ptr_r),
                       oval_r,
                       status_r};
  assign out_tuser  = empty;
  assign out_tlast  = dump_last;

endmodule

>>> test/bounded_list_deque_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_deque_engine_unit_tb
// Self-checking bench for the bounded list deque. Requests go in one beat at
// a time. A model of the list predicts the dump beats that follow each
// request, and every beat out is compared with the oldest prediction. Both
// ends idle at random, and the receiver once holds off long enough to stall
// the input side.
// ----------------------------------------------------------------------------
module bounded_list_deque_engine_unit_tb;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_REQS  = 141;
  localparam int unsigned HOLD_AT_BEAT = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [bldq_pkg::STATUS_W-1:0] status;
    logic [bldq_pkg::VALUE_W-1:0]  item_value;
    logic [bldq_pkg::INDEX_W-1:0]  item_index;
    logic [bldq_pkg::COUNT_W-1:0]  count;
    logic                          empty_res;
    logic                          last;
  } dump_beat_t;

  // list model plus the queue of dump beats still owed by the block
  class deque_scoreboard;
    logic [bldq_pkg::VALUE_W-1:0] contents[$];
    dump_beat_t                   pending_dump[$];
    int                           mismatch_count = 0;

    function void note_request(bldq_pkg::mode_t m, logic [bldq_pkg::VALUE_W-1:0] v,
                               logic [bldq_pkg::POS_W-1:0] p);
      logic [bldq_pkg::STATUS_W-1:0] sts;
      logic [bldq_pkg::VALUE_W-1:0]  tmp;
      int unsigned                   at;
      int unsigned                   n;
      dump_beat_t                    b;
      sts = bldq_pkg::STS_OK;
      n   = contents.size();
      case (m)
        bldq_pkg::MODE_PUSH_FRONT, bldq_pkg::MODE_PUSH_BACK, bldq_pkg::MODE_INSERT: begin
          if (n >= LIST_DEPTH) begin
            sts = bldq_pkg::STS_FULL;
          end else if (m == bldq_pkg::MODE_PUSH_FRONT) begin
            contents.push_front(v);
          end else if (m == bldq_pkg::MODE_PUSH_BACK) begin
            contents.push_back(v);
          end else begin
            at = (p < n) ? p : n;
            contents.insert(at, v);
          end
        end
        bldq_pkg::MODE_POP_FRONT, bldq_pkg::MODE_POP_BACK, bldq_pkg::MODE_DELETE: begin
          if (n == 0) begin
            sts = bldq_pkg::STS_EMPTY;
          end else if (m == bldq_pkg::MODE_POP_FRONT) begin
            contents.delete(0);
          end else if (m == bldq_pkg::MODE_POP_BACK) begin
            contents.delete(n - 1);
          end else begin
            // 1-based, clamped to 1..count
            at = (p < 1) ? 1 : p;
            if (at > n) at = n;
            contents.delete(at - 1);
          end
        end
        bldq_pkg::MODE_REVERSE: begin
          for (int i = 0; i < n / 2; i++) begin
            tmp = contents[i];
            contents[i] = contents[n - 1 - i];
            contents[n - 1 - i] = tmp;
          end
        end
        default: contents.delete();
      endcase

      n = contents.size();
      if (n == 0) begin
        b.status     = sts;
        b.item_value = '0;
        b.item_index = '0;
        b.count      = '0;
        b.empty_res  = 1'b1;
        b.last       = 1'b1;
        pending_dump.push_back(b);
      end else begin
        for (int i = 0; i < n; i++) begin
          b.status     = sts;
          b.item_value = contents[i];
          b.item_index = i[bldq_pkg::INDEX_W-1:0];
          b.count      = n[bldq_pkg::COUNT_W-1:0];
          b.empty_res  = 1'b0;
          b.last       = (i == n - 1);
          pending_dump.push_back(b);
        end
      end
    endfunction

    function void report(string field, logic [bldq_pkg::VALUE_W-1:0] want,
                         logic [bldq_pkg::VALUE_W-1:0] got);
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      mismatch_count++;
    endfunction

    function void check_beat(logic [bldq_pkg::OUT_TDATA_W-1:0] data, logic user, logic lastb);
      dump_beat_t want;
      dump_beat_t got;
      got.status     = data[1:0];
      got.item_value = data[33:2];
      got.item_index = data[37:34];
      got.count      = data[42:38];
      got.empty_res  = user;
      got.last       = lastb;
      if (pending_dump.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual data 0x%0h user %0b last %0b",
                 $time, data, user, lastb);
        mismatch_count++;
        return;
      end
      want = pending_dump.pop_front();
      if (got.status !== want.status)         report("status", want.status, got.status);
      if (got.item_value !== want.item_value) report("item_value", want.item_value,
                                                     got.item_value);
      if (got.item_index !== want.item_index) report("item_index", want.item_index,
                                                     got.item_index);
      if (got.count !== want.count)           report("count", want.count, got.count);
      if (got.empty_res !== want.empty_res)   report("empty_res", want.empty_res,
                                                     got.empty_res);
      if (got.last !== want.last)             report("last", want.last, got.last);
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [bldq_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [bldq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tlast;

  deque_scoreboard sb;
  int              send_calm;
  int              recv_calm;
  int unsigned     beats_seen;

  bounded_list_deque_engine_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long, with runs of no gaps at all
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(bldq_pkg::mode_t m, logic [bldq_pkg::VALUE_W-1:0] v,
                              logic [bldq_pkg::POS_W-1:0] p);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p, v, m};
    do @(posedge clk); while (!in_tready);
    sb.note_request(m, v, p);
    @(negedge clk);
  endtask

  task automatic random_requests();
    bit                         grow;
    int                         stuck;
    int                         r;
    bldq_pkg::mode_t            m;
    logic [bldq_pkg::POS_W-1:0] p;
    grow  = 1'b1;
    stuck = 0;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      // fill to full and poke at it, then drain to empty and poke at that
      if (grow && sb.contents.size() == LIST_DEPTH) begin
        stuck++;
        if (stuck >= 3) begin
          grow  = 1'b0;
          stuck = 0;
        end
      end else if (!grow && sb.contents.size() == 0) begin
        stuck++;
        if (stuck >= 2) begin
          grow  = 1'b1;
          stuck = 0;
        end
      end
      r = $urandom_range(0, 99);
      if (grow) begin
        if (r < 30)      m = bldq_pkg::MODE_PUSH_BACK;
        else if (r < 45) m = bldq_pkg::MODE_PUSH_FRONT;
        else if (r < 65) m = bldq_pkg::MODE_INSERT;
        else if (r < 70) m = bldq_pkg::MODE_POP_FRONT;
        else if (r < 75) m = bldq_pkg::MODE_POP_BACK;
        else if (r < 85) m = bldq_pkg::MODE_DELETE;
        else if (r < 98) m = bldq_pkg::MODE_REVERSE;
        else             m = bldq_pkg::MODE_CLEAR;
      end else begin
        if (r < 22)      m = bldq_pkg::MODE_POP_FRONT;
        else if (r < 44) m = bldq_pkg::MODE_POP_BACK;
        else if (r < 70) m = bldq_pkg::MODE_DELETE;
        else if (r < 74) m = bldq_pkg::MODE_PUSH_BACK;
        else if (r < 77) m = bldq_pkg::MODE_PUSH_FRONT;
        else if (r < 82) m = bldq_pkg::MODE_INSERT;
        else if (r < 96) m = bldq_pkg::MODE_REVERSE;
        else             m = bldq_pkg::MODE_CLEAR;
      end
      if ($urandom_range(0, 9) < 7) p = bldq_pkg::POS_W'($urandom_range(0, LIST_DEPTH));
      else                          p = bldq_pkg::POS_W'($urandom_range(0, 31));
      send_request(m, $urandom, p);
    end
  endtask

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    out_tready = 1'b0;
    beats_seen = 0;
    recv_calm  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_beat(out_tdata, out_tuser, out_tlast);
        beats_seen++;
      end
      @(negedge clk);
      if (rst_n) begin
        if (beats_seen == HOLD_AT_BEAT) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          beats_seen++;
        end else begin
          int gap;
          gap = pick_gap(recv_calm);
          if (gap > 0) begin
            out_tready <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    sb        = new();
    send_calm = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list: removals refused, reverse and clear harmless
    send_request(bldq_pkg::MODE_CLEAR,      32'h0000_0000, 5'd0);
    send_request(bldq_pkg::MODE_REVERSE,    32'hFFFF_FFFF, 5'd31);
    send_request(bldq_pkg::MODE_POP_FRONT,  32'h0000_0000, 5'd0);
    send_request(bldq_pkg::MODE_POP_BACK,   32'h0000_0000, 5'd0);
    send_request(bldq_pkg::MODE_DELETE,     32'h0000_0000, 5'd3);
    // extremes of value, insert index clamped and at the front
    send_request(bldq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF, 5'd0);
    send_request(bldq_pkg::MODE_PUSH_BACK,  32'h8000_0000, 5'd0);
    send_request(bldq_pkg::MODE_INSERT,     32'hFFFF_FFFF, 5'd31);
    send_request(bldq_pkg::MODE_INSERT,     32'h0000_0000, 5'd0);
    send_request(bldq_pkg::MODE_INSERT,     32'hAAAA_AAAA, 5'd2);
    send_request(bldq_pkg::MODE_REVERSE,    32'h0000_0000, 5'd0);
    // delete at position zero, past the end, and in the middle
    send_request(bldq_pkg::MODE_DELETE,     32'h0000_0000, 5'd0);
    send_request(bldq_pkg::MODE_DELETE,     32'h0000_0000, 5'd31);
    send_request(bldq_pkg::MODE_DELETE,     32'h0000_0000, 5'd2);
    send_request(bldq_pkg::MODE_POP_BACK,   32'h0000_0000, 5'd0);
    send_request(bldq_pkg::MODE_REVERSE,    32'h0000_0000, 5'd0);
    send_request(bldq_pkg::MODE_POP_FRONT,  32'h0000_0000, 5'd0);
    send_request(bldq_pkg::MODE_PUSH_BACK,  32'h5555_5555, 5'd16);
    send_request(bldq_pkg::MODE_CLEAR,      32'h0000_0000, 5'd0);

    random_requests();
    in_tvalid <= 1'b0;

    while (sb.pending_dump.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
